@@ hdl/dmf_pkg.sv @@
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types, constants and the band-pass coefficient table for the
// DSB mixer and FIR band-pass block.
// ----------------------------------------------------------------------------
package dmf_pkg;

  localparam int COEF_COUNT = 49;
  localparam int Q_SHIFT    = 15;
  localparam int APB_AW     = 3;

  typedef logic signed [15:0] sample_t;

  // Register map, indexed by paddr[2]
  localparam logic       REG_MIX_GAIN   = 1'b0;
  localparam logic [1:0] MIX_GAIN_RESET = 2'd2;

  localparam sample_t COEF_TABLE [COEF_COUNT] = '{
    16'sd109,   16'sd419,   -16'sd226,  -16'sd340,  16'sd210,   16'sd207,  -16'sd42,
    16'sd129,   -16'sd347,  -16'sd507,  16'sd813,   16'sd700,   -16'sd1033, -16'sd541,
    16'sd623,   16'sd49,    16'sd648,   16'sd548,   -16'sd2667, -16'sd927,  16'sd4934,
    16'sd856,   -16'sd6726, -16'sd346,  16'sd7407,  -16'sd346,  -16'sd6726, 16'sd856,
    16'sd4934,  -16'sd927,  -16'sd2667, 16'sd548,   16'sd648,   16'sd49,    16'sd623,
    -16'sd541,  -16'sd1033, 16'sd700,   16'sd813,   -16'sd507,  -16'sd347,  16'sd129,
    -16'sd42,   16'sd207,   16'sd210,   -16'sd340,  -16'sd226,  16'sd419,   16'sd109
  };

  // Taps past the end of the table weigh zero
  function automatic sample_t coef_at(input logic [7:0] idx);
    sample_t c;
    c = '0;
    if (idx < 8'(COEF_COUNT)) begin
      c = COEF_TABLE[idx[5:0]];
    end
    return c;
  endfunction

  typedef struct packed {
    logic    valid;
    sample_t dsb;
  } mix_out_t;

  typedef struct packed {
    logic    valid;
    sample_t y;
  } fir_res_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MAC,
    FS_DRAIN,
    FS_DONE
  } fir_state_t;

endpackage

@@ hdl/dsb_mixer_fir_bandpass.sv @@
// ----------------------------------------------------------------------------
// dsb_mixer_fir_bandpass
// DSB mixer followed by a fixed-coefficient band-pass FIR that shapes the
// modulated signal into a VSB sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries a message and a carrier sample;
//   output channel (out_valid/out_stall) returns one vsb_sample per request.
//   mix_gain is set over the APB port at byte address 0 (resets to 2); write
//   it only while the block is idle.
// Throughput:
//   One request at a time. From accept to result a request passes two mixer
//   stages, one delay-line memory read per tap through a single
//   multiply-accumulate pipe, its drain, and the write-back of the new
//   sample. The tap loop over the delay-line memory sets the rate.
// Reset:
//   rst is synchronous. The delay line reads as zeros until each entry has
//   been written, tracked by a fill count, so no clearing pass is needed.
// Backpressure:
//   The result sits in an output register; while out_stall holds it, the
//   filter finishes its next request and then waits for the register.
// ----------------------------------------------------------------------------
module dsb_mixer_fir_bandpass
  import dmf_pkg::*;
#(
  parameter int TAPS = 49
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  sample_t           message_sample,
  input  sample_t           carrier_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output sample_t           vsb_sample
);

  logic [1:0] mix_gain;
  logic       in_take;
  logic       mix_busy;
  logic       fir_busy;
  logic       out_free;
  mix_out_t   mix;
  fir_res_t   res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_gain <= MIX_GAIN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MIX_GAIN) begin
      mix_gain <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIX_GAIN) begin
      prdata = {30'b0, mix_gain};
    end
  end

  assign in_stall = mix_busy | fir_busy;
  assign in_take  = in_valid & ~in_stall;

  dmf_mixer u_mixer (
    .clk            (clk),
    .rst            (rst),
    .in_take        (in_take),
    .message_sample (message_sample),
    .carrier_sample (carrier_sample),
    .mix_gain       (mix_gain),
    .mix            (mix),
    .busy           (mix_busy)
  );

  dmf_fir #(
    .TAPS (TAPS)
  ) u_fir (
    .clk      (clk),
    .rst      (rst),
    .mix      (mix),
    .out_free (out_free),
    .res      (res),
    .busy     (fir_busy)
  );

  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      vsb_sample <= res.y;
    end
  end

endmodule

@@ hdl/dmf_mixer.sv @@
// ----------------------------------------------------------------------------
// dmf_mixer
// Two-stage mixer: message times carrier, Q15 floor shift, gain and
// saturation to 16 bits.
// ----------------------------------------------------------------------------
module dmf_mixer
  import dmf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_take,
  input  sample_t  message_sample,
  input  sample_t  carrier_sample,
  input  logic [1:0] mix_gain,
  output mix_out_t mix,
  output logic     busy
);

  logic               s1_vld;
  logic signed [31:0] prod;
  logic               dsb_vld;
  sample_t            dsb;
  sample_t            dsb_next;

  logic signed [16:0] shifted;
  logic signed [18:0] gained;

  always_comb begin
    // arithmetic shift gives the floor
    shifted = prod[31:Q_SHIFT];
    gained  = 19'(shifted) * $signed({17'b0, mix_gain});
    if (gained > 19'sd32767) begin
      dsb_next = 16'sh7fff;
    end else if (gained < -19'sd32768) begin
      dsb_next = 16'sh8000;
    end else begin
      dsb_next = gained[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      dsb_vld <= 1'b0;
    end else begin
      s1_vld  <= in_take;
      dsb_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      prod <= message_sample * carrier_sample;
    end
    if (s1_vld) begin
      dsb <= dsb_next;
    end
  end

  assign mix.valid = dsb_vld;
  assign mix.dsb   = dsb;
  assign busy      = s1_vld | dsb_vld;

endmodule

@@ hdl/dmf_delay_ram.sv @@
// ----------------------------------------------------------------------------
// dmf_delay_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module dmf_delay_ram
  import dmf_pkg::*;
#(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sample_t       wdata,
  input  logic [AW-1:0] raddr,
  output sample_t       rdata
);

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/dmf_fir.sv @@
// ----------------------------------------------------------------------------
// dmf_fir
// Band-pass FIR over a circular delay line in memory: one tap per cycle
// through a read, multiply and accumulate pipeline, then write-back.
// ----------------------------------------------------------------------------
module dmf_fir
  import dmf_pkg::*;
#(
  parameter int TAPS = 49
) (
  input  logic     clk,
  input  logic     rst,
  input  mix_out_t mix,
  input  logic     out_free,
  output fir_res_t res,
  output logic     busy
);

  localparam int DEPTH = TAPS - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(TAPS);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int ACC_W = 33 + $clog2(TAPS);
  localparam int SH_W  = ACC_W - Q_SHIFT;

  fir_state_t state;
  fir_state_t state_next;

  sample_t            dsb;
  logic [AW-1:0]      head;
  logic [FW-1:0]      fill;
  logic [TW-1:0]      issue_tap;
  logic               s1_vld;
  logic [TW-1:0]      s1_tap;
  logic               s1_live;
  logic               s2_vld;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic               start;
  logic               issue;
  logic               finish;
  logic               last_issue;

  logic [TW-1:0]      j_full;
  logic [AW-1:0]      j;
  logic [AW:0]        diff;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               live;
  sample_t            rdata;
  sample_t            op;
  logic signed [SH_W-1:0] sh;
  sample_t            y;

  dmf_delay_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (finish),
    .waddr (waddr),
    .wdata (dsb),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entry j of the delay line (newest first) sits at head - j, modulo DEPTH
  always_comb begin
    j_full = issue_tap - TW'(1);
    j      = AW'(j_full);
    diff   = {1'b0, head} - {1'b0, j};
    if (diff[AW]) begin
      raddr = AW'(diff + (AW + 1)'(DEPTH));
    end else begin
      raddr = diff[AW-1:0];
    end
    waddr      = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
    live       = FW'(j) < fill;
    last_issue = issue_tap == TW'(TAPS - 1);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE:  if (mix.valid) state_next = FS_MAC;
      FS_MAC:   if (last_issue) state_next = FS_DRAIN;
      FS_DRAIN: if (!s1_vld && !s2_vld) state_next = FS_DONE;
      FS_DONE:  if (out_free) state_next = FS_IDLE;
      default:  state_next = FS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    start  = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    unique case (state)
      FS_IDLE:  start  = mix.valid;
      FS_MAC:   issue  = 1'b1;
      FS_DRAIN: ;
      FS_DONE:  finish = out_free;
      default:  ;
    endcase
  end

  always_comb begin
    // tap 0 takes the fresh mixer sample, unwritten entries read as zero
    if (s1_tap == '0) begin
      op = dsb;
    end else if (s1_live) begin
      op = rdata;
    end else begin
      op = '0;
    end
    sh = acc[ACC_W-1:Q_SHIFT];
    if (sh > SH_W'(32767)) begin
      y = 16'sh7fff;
    end else if (sh < -SH_W'(32768)) begin
      y = 16'sh8000;
    end else begin
      y = sh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FS_IDLE;
      head   <= '0;
      fill   <= '0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      state  <= state_next;
      s1_vld <= issue;
      s2_vld <= s1_vld;
      if (finish) begin
        head <= waddr;
        if (fill != FW'(DEPTH)) begin
          fill <= fill + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsb <= mix.dsb;
    end
    if (start) begin
      issue_tap <= '0;
    end else if (issue) begin
      issue_tap <= issue_tap + TW'(1);
    end
    if (issue) begin
      s1_tap  <= issue_tap;
      s1_live <= live;
    end
    if (s1_vld) begin
      prod <= op * coef_at(8'(s1_tap));
    end
    if (start) begin
      acc <= '0;
    end else if (s2_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign res.valid = finish;
  assign res.y     = y;
  assign busy      = state != FS_IDLE;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("delay line fill count past depth");

  a_mix_when_idle: assert property (@(posedge clk) disable iff (rst)
    mix.valid |-> state == FS_IDLE)
    else $error("mixer sample arrived while filter busy");

  a_pipe_in_mac: assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> (state == FS_MAC || state == FS_DRAIN))
    else $error("accumulate outside MAC pass");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> (state == FS_IDLE && !s1_vld && !s2_vld))
    else $error("result issued with pipeline still active");
`endif

endmodule
